/* src/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths and constant tables for the phase to constellation point block.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int PhaseW = 16;
  localparam int CoordW = 16;
  localparam int SlotW  = 10;
  localparam int DegW   = 9;    // reduced angle 0..359
  localparam int RestW  = 7;    // angle within a quadrant 0..89
  localparam int MagW   = 15;   // table magnitude 0..16384

  localparam int RingDepthDefault        = 1024;
  localparam int SnapshotIntervalDefault = 256;

  localparam logic [DegW-1:0]  FullTurn    = 9'd360;
  localparam logic [DegW-1:0]  QuarterTurn = 9'd90;
  localparam logic [DegW-1:0]  HalfTurn    = 9'd180;
  localparam logic [DegW-1:0]  ThreeQuarts = 9'd270;
  localparam logic [RestW-1:0] QuarterIdx  = 7'd90;

  typedef logic [MagW-1:0] sine_table_t [91];
  typedef logic [DegW-1:0] hi_mod_t [256];

  // 16384*sin(k deg), rounded, k = 0..90
  localparam sine_table_t QuarterSine = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
      };

  // (signed high byte * 256) mod 360, indexed by the raw high byte
  function automatic hi_mod_t build_hi_mod();
    hi_mod_t t;
    int      h;
    for (int i = 0; i < 256; i++) begin
      h    = (i < 128) ? i : i - 256;
      t[i] = DegW'((((h * 256) % 360) + 360) % 360);
    end
    return t;
  endfunction

  localparam hi_mod_t HiModTable = build_hi_mod();

endpackage

/* src/phase_to_constellation_point.sv */
// ----------------------------------------------------------------------------
// phase_to_constellation_point
// Phase in whole degrees to a unit-circle point (cos, -sin) in Q1.14.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the input is not stalled and returns one
// point per sample. A sample taken is held in the input register; the angle
// reduction and the quarter-wave lookups run in one combinational pass from
// it, and the point lands in the result register once that register is free
// to take it, from where it is offered as valid on the master side. Only
// the two registers set the timing: the input stalls only while both hold an
// item and the master side is not ready.
// The modulo-360 step uses a 256-entry table on the high phase byte plus one
// compare-subtract. Each point carries the ring slot it belongs to (slot
// pointer pre-incremented, first sample gets slot 1) and tlast marks every
// SNAPSHOT_INTERVAL-th sample. No table or memory needs a fill after reset.
// ----------------------------------------------------------------------------
module phase_to_constellation_point
  import ptc_pkg::*;
#(
  parameter int RING_DEPTH        = RingDepthDefault,
  parameter int SNAPSHOT_INTERVAL = SnapshotIntervalDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] phase_degrees
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] point_x, [31:16] point_y,
                                      // [41:32] ring_slot, [47:42] zero
  output logic        m_axis_tlast    // snapshot_due
);

  localparam int PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CntW = (SNAPSHOT_INTERVAL > 1) ? $clog2(SNAPSHOT_INTERVAL) : 1;

  // pipeline control
  logic in_valid_q, out_valid_q;
  logic out_free, advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  logic [PhaseW-1:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      phase_q <= s_axis_tdata;
    end
  end

  // angle reduction: hi byte through table, lo byte added, one fold
  logic [DegW:0]     deg_sum;
  logic [DegW-1:0]   deg;
  logic [1:0]        quad;
  logic [DegW-1:0]   quad_base;
  logic [RestW-1:0]  rest, rest_inv, sin_idx, cos_idx;
  logic [MagW-1:0]   sin_mag, cos_mag;
  logic [CoordW-1:0] sin_ext, cos_ext;
  logic [CoordW-1:0] point_x_d, point_y_d;

  always_comb begin
    deg_sum = {1'b0, HiModTable[phase_q[15:8]]} + {{(DegW-7){1'b0}}, phase_q[7:0]};
    if (deg_sum >= {1'b0, FullTurn}) begin
      deg = DegW'(deg_sum - {1'b0, FullTurn});
    end else begin
      deg = deg_sum[DegW-1:0];
    end

    if (deg < QuarterTurn) begin
      quad = 2'd0; quad_base = '0;
    end else if (deg < HalfTurn) begin
      quad = 2'd1; quad_base = QuarterTurn;
    end else if (deg < ThreeQuarts) begin
      quad = 2'd2; quad_base = HalfTurn;
    end else begin
      quad = 2'd3; quad_base = ThreeQuarts;
    end

    rest     = RestW'(deg - quad_base);
    rest_inv = QuarterIdx - rest;
    // cos sits one quadrant ahead of sin
    sin_idx  = quad[0] ? rest_inv : rest;
    cos_idx  = quad[0] ? rest : rest_inv;
    sin_mag  = QuarterSine[sin_idx];
    cos_mag  = QuarterSine[cos_idx];
    sin_ext  = {1'b0, sin_mag};
    cos_ext  = {1'b0, cos_mag};

    point_x_d = (quad[1] ^ quad[0]) ? CoordW'(-cos_ext) : cos_ext;
    point_y_d = quad[1] ? sin_ext : CoordW'(-sin_ext);
  end

  // slot pointer and snapshot interval
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW:0]         cnt_inc;
  logic                  due_d;
  logic [PtrW+SlotW-1:0] slot_ext;

  always_comb begin
    if (ptr_q == PtrW'(RING_DEPTH - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + PtrW'(1);
    end
    cnt_inc = {1'b0, cnt_q} + (CntW + 1)'(1);
    due_d   = (cnt_inc == (CntW + 1)'(SNAPSHOT_INTERVAL));
    cnt_d   = due_d ? '0 : cnt_inc[CntW-1:0];
  end

  assign slot_ext = {{SlotW{1'b0}}, ptr_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ptr_q <= ptr_d;
        cnt_q <= cnt_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  logic [CoordW-1:0] point_x_q, point_y_q;
  logic [SlotW-1:0]  slot_q;
  logic              due_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      point_x_q <= point_x_d;
      point_y_q <= point_y_d;
      slot_q    <= slot_ext[SlotW-1:0];
      due_q     <= due_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, slot_q, point_y_q, point_x_q};
  assign m_axis_tlast  = due_q;

  // checks
  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> (deg < FullTurn && rest < QuarterIdx))
    else $error("reduced angle out of range");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(RING_DEPTH - 1))
    else $error("slot pointer beyond ring depth");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < (CntW + 1)'(SNAPSHOT_INTERVAL))
    else $error("interval count beyond snapshot interval");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipe");

  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (ptr_q == $past(ptr_d)))
    else $error("slot pointer did not step on transfer");

endmodule
